// File: rtl/mkd_pkg.sv
package mkd_pkg;

  localparam int KEY_W      = 4;
  localparam int MAX_KEYS   = 16;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 64;
  localparam int QUEUE_DEPTH = 2;
  localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
  localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_DEBOUNCE_MS   = 3'd0,
    CFG_ACTIVE_HIGH   = 3'd1,
    CFG_KEYMAP_ENABLE = 3'd2,
    CFG_KEYMAP_LOW    = 3'd3,
    CFG_KEYMAP_HIGH   = 3'd4
  } cfg_index_t;

  typedef struct packed {
    logic [15:0] debounce_ms;
    logic        active_high;
    logic        keymap_enable;
    logic [63:0] keymap_low;
    logic [63:0] keymap_high;
  } cfg_t;

  // Events caused by one scan: an optional release, then an optional press.
  typedef struct packed {
    logic             rel_valid;
    logic [KEY_W-1:0] rel_index;
    logic             press_valid;
    logic [KEY_W-1:0] press_index;
  } scan_events_t;

  typedef enum logic {
    EVT_RELEASED = 1'b0,
    EVT_PRESSED  = 1'b1
  } event_kind_t;

endpackage

// File: rtl/mkd_front.sv
module mkd_front import mkd_pkg::*; #(
  parameter int NKEYS = 16
) (
  input  logic                  clk,
  input  logic                  rst,
  input  cfg_t                  cfg,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [MAX_KEYS-1:0]   key_levels,
  input  logic [31:0]           now_ms,
  input  logic                  q_full,
  output logic                  push,
  output scan_events_t          push_data
);

  logic             candidate_valid, candidate_valid_next;
  logic [KEY_W-1:0] candidate_index, candidate_index_next;
  logic [31:0]      candidate_since, candidate_since_next;
  logic             reported_valid, reported_valid_next;
  logic [KEY_W-1:0] reported_index, reported_index_next;

  logic [MAX_KEYS-1:0] active;
  logic [MAX_KEYS-1:0] active_less;
  logic                ghost;
  logic                key_valid;
  logic [KEY_W-1:0]    key;
  logic                accept;
  logic                changed;
  logic                rel;
  logic                press;
  logic                rep_valid_mid;
  logic [KEY_W-1:0]    rep_index_mid;
  logic [31:0]         since_eff;
  logic [31:0]         elapsed;

  assign in_stall = q_full;
  assign accept   = in_valid && !q_full;

  always_comb begin
    for (int i = 0; i < MAX_KEYS; i++) begin
      active[i] = (i < NKEYS) && (key_levels[i] == cfg.active_high);
    end
  end

  // Two or more set bits: clearing the lowest one leaves something behind.
  assign active_less = active - MAX_KEYS'(1);
  assign ghost       = |(active & active_less);
  assign key_valid   = |active;

  always_comb begin
    key = '0;
    for (int i = MAX_KEYS - 1; i >= 0; i--) begin
      if (active[i]) key = KEY_W'(i);
    end
  end

  assign changed = (key_valid != candidate_valid) ||
                   (key_valid && (key != candidate_index));
  assign rel     = changed && candidate_valid && reported_valid &&
                   (reported_index == candidate_index);
  assign rep_valid_mid = rel ? 1'b0 : reported_valid;
  assign rep_index_mid = rel ? '0 : reported_index;
  assign since_eff     = (changed && key_valid) ? now_ms : candidate_since;
  assign elapsed       = now_ms - since_eff;
  assign press = key_valid && !(rep_valid_mid && (rep_index_mid == key)) &&
                 (elapsed >= {16'd0, cfg.debounce_ms});

  always_comb begin
    candidate_valid_next = candidate_valid;
    candidate_index_next = candidate_index;
    candidate_since_next = candidate_since;
    reported_valid_next  = reported_valid;
    reported_index_next  = reported_index;
    if (accept && !ghost) begin
      if (changed) begin
        candidate_valid_next = key_valid;
        candidate_index_next = key_valid ? key : '0;
        candidate_since_next = since_eff;
      end
      reported_valid_next = press ? 1'b1 : rep_valid_mid;
      reported_index_next = press ? key : rep_index_mid;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      candidate_valid <= 1'b0;
      candidate_index <= '0;
      candidate_since <= '0;
      reported_valid  <= 1'b0;
      reported_index  <= '0;
    end else begin
      candidate_valid <= candidate_valid_next;
      candidate_index <= candidate_index_next;
      candidate_since <= candidate_since_next;
      reported_valid  <= reported_valid_next;
      reported_index  <= reported_index_next;
    end
  end

  assign push                  = accept && !ghost && (rel || press);
  assign push_data.rel_valid   = rel;
  assign push_data.rel_index   = reported_index;
  assign push_data.press_valid = press;
  assign push_data.press_index = key;

`ifndef SYNTHESIS
  // A reported key is always the current candidate.
  a_reported_is_candidate: assert property (@(posedge clk) disable iff (rst)
    reported_valid |-> (candidate_valid && (reported_index == candidate_index)))
    else $error("reported key is not the candidate");

  // A ghosting scan leaves the candidate untouched.
  a_ghost_no_change: assert property (@(posedge clk) disable iff (rst)
    (accept && ghost) |=> ($stable(candidate_valid) && $stable(candidate_index) &&
                           $stable(candidate_since)))
    else $error("ghosting scan changed the candidate");
`endif

endmodule

// File: rtl/mkd_queue.sv
module mkd_queue import mkd_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  logic         push,
  input  scan_events_t push_data,
  output logic         full,
  input  logic         pop,
  output logic         empty,
  output scan_events_t head
);

  scan_events_t             entries [QUEUE_DEPTH];
  logic [QUEUE_PTR_W-1:0]   wr_ptr;
  logic [QUEUE_PTR_W-1:0]   rd_ptr;
  logic [QUEUE_CNT_W-1:0]   count;

  assign full  = (count == QUEUE_CNT_W'(QUEUE_DEPTH));
  assign empty = (count == '0);
  assign head  = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) entries[wr_ptr] <= push_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= (wr_ptr == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      if (pop)  rd_ptr <= (rd_ptr == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      count <= count + QUEUE_CNT_W'(push) - QUEUE_CNT_W'(pop);
    end
  end

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    !(push && full && !pop))
    else $error("event queue overflow");

  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    !(pop && empty))
    else $error("event queue underflow");
`endif

endmodule

// File: rtl/mkd_back.sv
module mkd_back import mkd_pkg::*; #(
  parameter int ROWS = 4,
  parameter int COLS = 4
) (
  input  logic         clk,
  input  logic         rst,
  input  cfg_t         cfg,
  input  logic         q_empty,
  input  scan_events_t head,
  output logic         pop,
  output logic         out_valid,
  input  logic         out_stall,
  output logic         event_kind,
  output logic [1:0]   key_row,
  output logic [1:0]   key_col,
  output logic [3:0]   key_index,
  output logic [7:0]   keycode,
  output logic         keycode_valid,
  output logic         last
);

  logic             rel_done;
  logic             load;
  logic             emit_rel;
  logic [KEY_W-1:0] idx;
  logic [1:0]       row;
  logic [KEY_W-1:0] base;
  logic [127:0]     keymap;
  logic [6:0]       bit_pos;

  assign load     = !q_empty && (!out_valid || !out_stall);
  assign emit_rel = head.rel_valid && !rel_done;
  // Hold the entry while its press still waits behind the release.
  assign pop      = load && !(emit_rel && head.press_valid);
  assign idx      = emit_rel ? head.rel_index : head.press_index;

  always_comb begin
    row  = '0;
    base = '0;
    for (int r = 1; r < ROWS; r++) begin
      if ({1'b0, idx} >= 5'(r * COLS)) begin
        row  = 2'(r);
        base = KEY_W'(r * COLS);
      end
    end
  end

  assign keymap  = {cfg.keymap_high, cfg.keymap_low};
  assign bit_pos = {idx, 3'b000};

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      rel_done  <= 1'b0;
    end else begin
      if (load) begin
        out_valid <= 1'b1;
        rel_done  <= emit_rel && head.press_valid;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      event_kind    <= emit_rel ? EVT_RELEASED : EVT_PRESSED;
      key_row       <= row;
      key_col       <= 2'(idx - base);
      key_index     <= idx;
      keycode       <= cfg.keymap_enable ? keymap[bit_pos +: 8] : 8'd0;
      keycode_valid <= cfg.keymap_enable;
      last          <= !(emit_rel && head.press_valid);
    end
  end

`ifndef SYNTHESIS
  // Only a release can be followed by another beat of the same scan.
  a_non_last_is_release: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !last) |-> (event_kind == EVT_RELEASED))
    else $error("press beat not marked last");

  a_rel_done_pending: assert property (@(posedge clk) disable iff (rst)
    rel_done |-> !q_empty)
    else $error("release done with no entry pending");
`endif

endmodule

// File: rtl/matrix_keypad_debouncer_top.sv
// Matrix keypad debouncer: takes one full scan per beat (a level bit per key at
// row*COLS+col, plus a millisecond timestamp) and reports release and press
// events with row, column, index and mapped keycode. Scans with two or more
// active keys are dropped as ghosting. A new scan is accepted every cycle while
// the two-entry event queue has room; the output stage sends one event per
// cycle while out_stall is low, a scan that causes a release followed by a press
// sends both as separate events, and the output stage sets the sustained rate.
// Write configuration only while no events are pending.
module matrix_keypad_debouncer_top import mkd_pkg::*; #(
  parameter int ROWS = 4,
  parameter int COLS = 4
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_write_enable,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [15:0]           key_levels,
  input  logic [31:0]           now_ms,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic                  event_kind,
  output logic [1:0]            key_row,
  output logic [1:0]            key_col,
  output logic [3:0]            key_index,
  output logic [7:0]            keycode,
  output logic                  keycode_valid,
  output logic                  last
);

  localparam int NKEYS = ROWS * COLS;

  cfg_t         cfg;
  logic         q_push;
  logic         q_pop;
  logic         q_full;
  logic         q_empty;
  scan_events_t q_in;
  scan_events_t q_head;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.debounce_ms   <= 16'd1;
      cfg.active_high   <= 1'b0;
      cfg.keymap_enable <= 1'b0;
      cfg.keymap_low    <= '0;
      cfg.keymap_high   <= '0;
    end else if (cfg_write_enable) begin
      unique case (cfg_index)
        CFG_DEBOUNCE_MS:   cfg.debounce_ms   <= cfg_data[15:0];
        CFG_ACTIVE_HIGH:   cfg.active_high   <= cfg_data[0];
        CFG_KEYMAP_ENABLE: cfg.keymap_enable <= cfg_data[0];
        CFG_KEYMAP_LOW:    cfg.keymap_low    <= cfg_data;
        CFG_KEYMAP_HIGH:   cfg.keymap_high   <= cfg_data;
        default: ;
      endcase
    end
  end

  mkd_front #(
    .NKEYS(NKEYS)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .key_levels(key_levels),
    .now_ms    (now_ms),
    .q_full    (q_full),
    .push      (q_push),
    .push_data (q_in)
  );

  mkd_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (q_push),
    .push_data(q_in),
    .full     (q_full),
    .pop      (q_pop),
    .empty    (q_empty),
    .head     (q_head)
  );

  mkd_back #(
    .ROWS(ROWS),
    .COLS(COLS)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .q_empty      (q_empty),
    .head         (q_head),
    .pop          (q_pop),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .event_kind   (event_kind),
    .key_row      (key_row),
    .key_col      (key_col),
    .key_index    (key_index),
    .keycode      (keycode),
    .keycode_valid(keycode_valid),
    .last         (last)
  );

endmodule

// File: dv/matrix_keypad_debouncer_top_tb.sv
module matrix_keypad_debouncer_top_tb;
  import mkd_pkg::*;

  localparam int KEY_COLS = 4;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_IDX = 3'd7;

  typedef struct packed {
    event_kind_t kind;
    logic [1:0]  row;
    logic [1:0]  col;
    logic [3:0]  idx;
    logic [7:0]  code;
    logic        code_valid;
    logic        tail;
  } key_event_t;

  // Tracks the debouncer state and the key events still owed by the block.
  class key_event_predictor;
    logic [15:0] debounce;
    logic        active_high;
    logic        keymap_on;
    logic [63:0] map_lo;
    logic [63:0] map_hi;
    logic        cand_on;
    logic [3:0]  cand_key;
    logic [31:0] cand_since;
    logic        shown_on;
    logic [3:0]  shown_key;
    key_event_t  expected_events[$];
    int          scans;
    int          ghosts;
    int          checked;
    int          presses;
    int          failures;

    function new();
      debounce    = 16'd1;
      active_high = 1'b0;
      keymap_on   = 1'b0;
      map_lo      = '0;
      map_hi      = '0;
      cand_on     = 1'b0;
      cand_key    = '0;
      cand_since  = '0;
      shown_on    = 1'b0;
      shown_key   = '0;
      scans       = 0;
      ghosts      = 0;
      checked     = 0;
      presses     = 0;
      failures    = 0;
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        CFG_DEBOUNCE_MS:   debounce = data[15:0];
        CFG_ACTIVE_HIGH:   active_high = data[0];
        CFG_KEYMAP_ENABLE: keymap_on = data[0];
        CFG_KEYMAP_LOW:    map_lo = data;
        CFG_KEYMAP_HIGH:   map_hi = data;
        default: ;
      endcase
    endfunction

    function int pending();
      return expected_events.size();
    endfunction

    function key_event_t make_event(event_kind_t kind, logic [3:0] k);
      key_event_t ev;
      logic [63:0] word;
      word = k[3] ? map_hi : map_lo;
      ev.kind       = kind;
      ev.row        = 2'(k / KEY_COLS);
      ev.col        = 2'(k % KEY_COLS);
      ev.idx        = k;
      ev.code       = keymap_on ? word[{k[2:0], 3'b000} +: 8] : 8'h00;
      ev.code_valid = keymap_on;
      ev.tail       = 1'b0;
      return ev;
    endfunction

    function void note_scan(logic [15:0] levels, logic [31:0] stamp);
      int unsigned hits;
      logic [3:0]  hit_key;
      logic        key_on;
      key_event_t  evs[$];
      hits    = 0;
      hit_key = '0;
      scans++;
      for (int i = 0; i < MAX_KEYS; i++) begin
        if (levels[i] == active_high) begin
          if (hits == 0) hit_key = 4'(i);
          hits++;
        end
      end
      // ghosting: drop the scan, keep all state
      if (hits >= 2) begin
        ghosts++;
        return;
      end
      key_on = (hits == 1);
      if (key_on != cand_on || (key_on && hit_key != cand_key)) begin
        if (cand_on && shown_on && shown_key == cand_key) begin
          evs = {evs, make_event(EVT_RELEASED, shown_key)};
          shown_on  = 1'b0;
          shown_key = '0;
        end
        cand_on  = key_on;
        cand_key = key_on ? hit_key : 4'd0;
        if (key_on) cand_since = stamp;
      end
      if (key_on && !(shown_on && shown_key == hit_key) &&
          32'(stamp - cand_since) >= {16'd0, debounce}) begin
        evs = {evs, make_event(EVT_PRESSED, hit_key)};
        shown_on  = 1'b1;
        shown_key = hit_key;
      end
      if (evs.size() > 0) evs[evs.size() - 1].tail = 1'b1;
      expected_events = {expected_events, evs};
    endfunction

    function string describe(key_event_t ev);
      return $sformatf("%s key %0d (row %0d col %0d) code %02h valid %0b last %0b",
                       ev.kind == EVT_PRESSED ? "press" : "release", ev.idx, ev.row,
                       ev.col, ev.code, ev.code_valid, ev.tail);
    endfunction

    function void flag(string what);
      failures++;
      if (failures <= 10) $display("mismatch: %s", what);
    endfunction

    function void check_event(key_event_t got);
      key_event_t want;
      checked++;
      if (got.kind == EVT_PRESSED) presses++;
      if (expected_events.size() == 0) begin
        flag({"event with nothing pending: ", describe(got)});
        return;
      end
      want = expected_events.pop_front();
      if (got !== want)
        flag({"expected ", describe(want), ", got ", describe(got)});
    endfunction

    function void close_out();
      foreach (expected_events[i])
        flag({"never seen: ", describe(expected_events[i])});
      expected_events.delete();
    endfunction
  endclass

  logic                  clk;
  logic                  rst;
  logic                  cfg_write_enable;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  logic                  in_valid;
  logic                  in_stall;
  logic [15:0]           key_levels;
  logic [31:0]           now_ms;
  logic                  out_valid;
  logic                  out_stall;
  logic                  event_kind;
  logic [1:0]            key_row;
  logic [1:0]            key_col;
  logic [3:0]            key_index;
  logic [7:0]            keycode;
  logic                  keycode_valid;
  logic                  last;

  matrix_keypad_debouncer_top u_dut (
    .clk              (clk),
    .rst              (rst),
    .cfg_write_enable (cfg_write_enable),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .key_levels       (key_levels),
    .now_ms           (now_ms),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .event_kind       (event_kind),
    .key_row          (key_row),
    .key_col          (key_col),
    .key_index        (key_index),
    .keycode          (keycode),
    .keycode_valid    (keycode_valid),
    .last             (last)
  );

  key_event_predictor pred = new();

  bit          in_idle_on;
  bit          out_idle_on;
  int          hold_request;
  logic [31:0] stamp_ms;
  int unsigned step_max;
  int          phase_scans;
  int          settings_used;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #10_000_000;
    $display("matrix_keypad_debouncer_top verification failed");
    $finish;
  end

  // Called at a falling edge; returns at the falling edge after acceptance.
  task automatic send_scan(input logic [15:0] levels, input logic [31:0] stamp);
    int gap;
    gap = in_idle_on ? $urandom_range(0, 13) : 0;
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid   = 1'b1;
    key_levels = levels;
    now_ms     = stamp;
    do @(posedge clk); while (in_stall);
    pred.note_scan(levels, stamp);
    @(negedge clk);
  endtask

  task automatic drain_events();
    in_valid = 1'b0;
    while (pred.pending() != 0) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_write_enable = 1'b1;
    cfg_index        = idx;
    cfg_data         = data;
    pred.set_reg(idx, data);
    @(negedge clk);
    cfg_write_enable = 1'b0;
  endtask

  // Drain events, wait out a scan that may still be in flight without causing an event, then write every setting.
  task automatic load_settings(input logic [15:0] deb, input logic hi, input logic map_on,
                               input logic [63:0] lo_map, input logic [63:0] hi_map);
    drain_events();
    repeat (8) @(negedge clk);
    write_reg(CFG_DEBOUNCE_MS, 64'(deb));
    write_reg(CFG_ACTIVE_HIGH, 64'(hi));
    write_reg(CFG_KEYMAP_ENABLE, 64'(map_on));
    write_reg(CFG_KEYMAP_LOW, lo_map);
    write_reg(CFG_KEYMAP_HIGH, hi_map);
    step_max = (deb == 0) ? 3 : deb / 2 + 1;
    settings_used++;
  endtask

  task automatic next_scan(input logic [15:0] act);
    if ($urandom_range(0, 39) == 0) stamp_ms = $urandom;
    else stamp_ms += $urandom_range(0, step_max);
    send_scan(pred.active_high ? act : ~act, stamp_ms);
    phase_scans++;
  endtask

  function automatic logic [15:0] ghost_pattern(input int k);
    int other;
    other = (k + $urandom_range(1, 15)) % MAX_KEYS;
    return (16'(1) << k) | (16'(1) << other) |
           (($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'h0000);
  endfunction

  // Receiver: check the beat taken at the rising edge, then drive the stall.
  initial begin
    bit         took;
    key_event_t seen;
    int         stall_left;
    int         hold_left;
    out_stall  = 1'b0;
    stall_left = 0;
    hold_left  = 0;
    forever begin
      @(posedge clk);
      took = (out_valid === 1'b1) && !out_stall;
      seen = {event_kind, key_row, key_col, key_index, keycode, keycode_valid, last};
      @(negedge clk);
      if (took) begin
        pred.check_event(seen);
        stall_left = out_idle_on ? $urandom_range(0, 13) : 0;
      end
      if (hold_request > 0) begin
        hold_left    = hold_request;
        hold_request = 0;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall = 1'b1;
      end else if (stall_left > 0) begin
        stall_left--;
        out_stall = 1'b1;
      end else begin
        out_stall = 1'b0;
      end
    end
  end

  initial begin
    logic [15:0] deb;
    int          r;
    int          k;
    int          len;
    bit          hold_done;
    bit          pause_done;
    rst              = 1'b1;
    cfg_write_enable = 1'b0;
    cfg_index        = CFG_DEBOUNCE_MS;
    cfg_data         = '0;
    in_valid         = 1'b0;
    key_levels       = '0;
    now_ms           = '0;
    in_idle_on       = 1'b1;
    out_idle_on      = 1'b1;
    hold_request     = 0;
    stamp_ms         = '0;
    step_max         = 1;
    settings_used    = 1;
    hold_done        = 1'b0;
    pause_done       = 1'b0;
    repeat (9) @(negedge clk);
    rst = 1'b0;

    // reset settings: debounce 1, active low, no keymap
    send_scan(16'hFFFF, 32'd0);
    send_scan(16'hFFFE, 32'd10);
    send_scan(16'hFFFE, 32'd11);
    send_scan(16'hFFFC, 32'd12);
    send_scan(16'h0000, 32'd13);
    send_scan(16'h7FFF, 32'd14);
    send_scan(16'h7FFF, 32'd15);
    send_scan(16'hFFFF, 32'd16);

    // zero debounce, active high: release and press out of one scan
    load_settings(16'd0, 1'b1, 1'b1, 64'h0123_4567_89AB_CDEF, 64'hFEDC_BA98_7654_3210);
    write_reg(CFG_SPARE_IDX, 64'hDEAD_BEEF_0BAD_F00D);
    send_scan(16'h0001, 32'hFFFF_FFFF);
    send_scan(16'h8000, 32'h0000_0000);
    send_scan(16'h8000, 32'h0000_0005);
    send_scan(16'h0000, 32'h0000_0006);
    send_scan(16'h00A0, 32'h0000_0007);
    send_scan(16'hFFFF, 32'h0000_0008);

    // longest debounce, measured across the timestamp wrap
    load_settings(16'hFFFF, 1'b1, 1'b1, 64'h0, 64'hFFFF_FFFF_FFFF_FFFF);
    send_scan(16'h0100, 32'hFFFF_8000);
    send_scan(16'h0100, 32'h0000_7FFE);
    send_scan(16'h0100, 32'h0000_7FFF);
    send_scan(16'h0000, 32'h0000_8000);

    for (int p = 0; p < 8; p++) begin
      case (p)
        0:       deb = 16'd0;
        1:       deb = 16'hFFFF;
        default: deb = ($urandom_range(0, 5) == 0) ? 16'($urandom_range(9, 65535))
                                                   : 16'($urandom_range(1, 6));
      endcase
      load_settings(deb, p[0] ^ 1'b1, ($urandom_range(0, 2) != 0),
                    {$urandom, $urandom}, {$urandom, $urandom});
      in_idle_on  = ($urandom_range(0, 3) != 0);
      out_idle_on = ($urandom_range(0, 3) != 0);
      phase_scans = 0;
      while (phase_scans < 240) begin
        if (p == 3 && phase_scans >= 100 && !hold_done) begin
          hold_request = 300;
          hold_done    = 1'b1;
        end
        if (p == 5 && phase_scans >= 120 && !pause_done) begin
          drain_events();
          pause_done = 1'b1;
        end
        r = $urandom_range(0, 9);
        if (r <= 6) begin
          // hold one key for a few scans, now and then through a ghost
          k   = $urandom_range(0, 15);
          len = $urandom_range(1, 6);
          for (int j = 0; j < len; j++) begin
            if ($urandom_range(0, 7) == 0) next_scan(ghost_pattern(k));
            next_scan(16'(1) << k);
          end
          if ($urandom_range(0, 1) != 0) next_scan(16'h0000);
        end else if (r == 7) begin
          repeat ($urandom_range(1, 3)) next_scan(16'h0000);
        end else if (r == 8) begin
          next_scan(ghost_pattern($urandom_range(0, 15)));
        end else begin
          next_scan(16'($urandom));
        end
      end
    end

    in_valid = 1'b0;
    for (int w = 0; w < 5000 && pred.pending() != 0; w++) @(negedge clk);
    repeat (16) @(negedge clk);
    pred.close_out();

    $display("%0d scans (%0d dropped as ghosting) under %0d settings", pred.scans,
             pred.ghosts, settings_used);
    $display("%0d key events checked, %0d presses, %0d failures", pred.checked,
             pred.presses, pred.failures);
    if (pred.failures == 0) begin
      $display("matrix_keypad_debouncer_top verification clean");
    end else begin
      $display("matrix_keypad_debouncer_top verification failed");
    end
    $finish;
  end

endmodule
